// ===== rtl/plst_pkg.sv =====
// plst_pkg: shared types and codes of the positional list engine
// no dependencies; compile before every other rtl file
`default_nettype none

package plst_pkg;

    // payload field widths of the request and response channels
    localparam int REQ_TYPE_W = 2;
    localparam int POS_W      = 7;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // operation broadcast along the chain of cells
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    // request sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/plst_req_if.sv =====
// plst_req_if: request channel (valid/ready plus request payload)
// depends on plst_pkg
`default_nettype none

interface plst_req_if;
    import plst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POS_W-1:0]      pos;
    logic [VALUE_W-1:0]    value;

    modport source (output valid, output req_type, output pos, output value, input ready);
    modport sink   (input valid, input req_type, input pos, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/plst_rsp_if.sv =====
// plst_rsp_if: response channel (valid/ready plus response payload)
// depends on plst_pkg
`default_nettype none

interface plst_rsp_if;
    import plst_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output read_value, output status, output count, input ready);
    modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/plst_cell.sv =====
// plst_cell: one storage cell of the chain, holds one data word
// depends on plst_pkg; instantiated once per entry by positional_list_engine
`default_nettype none

module plst_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6
) (
    input  wire                     i_clk,
    input  wire plst_pkg::t_cell_op i_op,
    input  wire  [IDX_W-1:0]        i_at,
    input  wire  [IDX_W-1:0]        i_idx,
    input  wire  [DATA_WIDTH-1:0]   i_word,
    input  wire  [DATA_WIDTH-1:0]   i_prev,
    input  wire  [DATA_WIDTH-1:0]   i_next,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [DATA_WIDTH-1:0]   o_rd
);
    import plst_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_hit;
    logic                  w_after;

    assign w_hit   = (i_idx == i_at);
    assign w_after = (i_idx > i_at);

    // insert takes the word at the position and the neighbour's word beyond it;
    // delete pulls the next neighbour's word from the position onwards
    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_INS: begin
                if (w_hit) begin
                    n_data = i_word;
                end else if (w_after) begin
                    n_data = i_prev;
                end
            end
            CELL_DEL: begin
                if (w_hit || w_after) begin
                    n_data = i_next;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // contents are undefined until written, so no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // masked word for the one-hot read reduction
    assign o_rd   = w_hit ? r_data : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// positional_list_engine: ordered word list with insert/delete/read by position
// depends on plst_pkg, plst_req_if, plst_rsp_if and plst_cell
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    req_type[1:0] pos[6:0] value[31:0]
//   o_rsp     out  valid/ready    read_value[31:0] status[1:0] count[6:0]
//
// a request passes through capture, execute in the cell chain, then the
// read word is reduced from the cells in groups of 32 and a final OR stage
// so a new request is taken only once the previous one has left the reduce step
// reset clears the sequencer, the held count and the response valid; the
// cell contents are left as they are
// a stalled response waits in the output register; one further request may
// be taken and executed meanwhile and then holds in the reduce step
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    plst_req_if.sink    i_req,
    plst_rsp_if.source  o_rsp
);
    import plst_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int GRP   = 32;
    localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

    // sequencer and request registers
    t_state                r_state;
    t_state                n_state;
    logic [REQ_TYPE_W-1:0] r_req_type;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_word;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic                  r_read_ok;
    logic                  n_read_ok;
    logic [DATA_WIDTH-1:0] r_grp [NGRP];

    // response registers
    logic                  r_o_valid;
    logic [VALUE_W-1:0]    r_o_value;
    logic [STATUS_W-1:0]   r_o_status;
    logic [COUNT_W-1:0]    r_o_count;

    logic                  w_in_take;
    logic                  w_out_free;
    logic                  w_load_out;
    t_cell_op              w_op;
    logic [IDX_W-1:0]      w_at;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic                  w_full;
    logic                  w_ins_ok;
    logic                  w_in_rng;
    logic [EXT_W-1:0]      w_value_x;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_red;
    logic [EXT_W-1:0]      w_red_x;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd   [CAPACITY];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_take   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_o_valid || o_rsp.ready;

    // word kept in its low DATA_WIDTH bits
    assign w_value_x = EXT_W'(i_req.value);
    assign w_word    = w_value_x[DATA_WIDTH-1:0];

    // range checks on the captured request
    assign w_pos_x  = CMP_W'(r_pos);
    assign w_cnt_x  = CMP_W'(r_count);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_ins_ok = (r_pos != '0) && (w_pos_x <= w_cnt_x + CMP_W'(1));
    assign w_in_rng = (r_pos != '0) && (w_pos_x <= w_cnt_x);
    assign w_at     = IDX_W'(w_pos_x - CMP_W'(1));

    // next state, cell operation and status
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_status  = r_status;
        n_read_ok = r_read_ok;
        w_op      = CELL_HOLD;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = STAT_OK;
                n_read_ok = 1'b0;
                case (r_req_type)
                    REQ_INSERT: begin
                        if (w_full) begin
                            n_status = STAT_FULL;
                        end else if (!w_ins_ok) begin
                            n_status = STAT_BAD_POS;
                        end else begin
                            w_op    = CELL_INS;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    REQ_DELETE: begin
                        if (w_in_rng) begin
                            w_op    = CELL_DEL;
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_status = STAT_BAD_POS;
                        end
                    end
                    REQ_READ: begin
                        if (w_in_rng) begin
                            n_read_ok = 1'b1;
                        end else begin
                            n_status = STAT_BAD_POS;
                        end
                    end
                    default: n_status = STAT_OK;
                endcase
                n_state = S_REDUCE;
            end
            S_REDUCE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request capture and status staging
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req_type <= i_req.req_type;
            r_pos      <= i_req.pos;
            r_word     <= w_word;
        end
        r_status  <= n_status;
        r_read_ok <= n_read_ok;
    end

    // chain of cells, each handing its word to both neighbours
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;

        if (c == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_mid_p
            assign w_prev = w_data[c-1];
        end
        if (c == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid_n
            assign w_next = w_data[c+1];
        end

        plst_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_at   (w_at),
            .i_idx  (IDX_W'(c)),
            .i_word (r_word),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[c]),
            .o_rd   (w_rd[c])
        );
    end

    // first reduction level: one-hot OR over groups of cells
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [DATA_WIDTH-1:0] w_or;

        always_comb begin
            w_or = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    w_or = w_or | w_rd[g * GRP + k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_or;
        end
    end

    // final reduction level over the group registers
    always_comb begin
        w_red = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_red = w_red | r_grp[g];
        end
    end

    assign w_red_x = EXT_W'(w_red);

    // response register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_value  <= r_read_ok ? w_red_x[VALUE_W-1:0] : '0;
            r_o_status <= r_status;
            r_o_count  <= COUNT_W'(r_count);
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.read_value = r_o_value;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.count      = r_o_count;

endmodule

`default_nettype wire
